// File: hdl/rtmam_pkg.sv
// Package for the running temperature minimum / average / maximum block.
// Holds the field types, operation codes, limits and controller states.
// No dependencies; every other file of the block imports it.
package rtmam_pkg;

	typedef logic signed [10:0] temp_t;
	typedef logic [9:0] humid_t;
	typedef logic [6:0] pct_t;
	typedef logic [7:0] count_t;
	typedef logic signed [18:0] sum_t;

	typedef enum logic [1:0] {
		OP_SAMPLE    = 2'd0,
		OP_SET_EXTR  = 2'd1,
		OP_CLEAR_WIN = 2'd2
	} op_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DIVIDE,
		ST_FINISH
	} state_t;

	localparam temp_t TEMP_LO = -11'sd400;
	localparam temp_t TEMP_HI = 11'sd800;
	localparam humid_t HUMID_HI = 10'd1000;
	localparam count_t COUNT_MAX = 8'd255;
	localparam count_t WINDOW_RESET = 8'd200;
	localparam int MAG_W = 18;
	localparam logic [4:0] DIV_LAST = 5'd17;
	localparam logic [4:0] HUM_DIVISOR = 5'd10;

endpackage

// File: hdl/rtmam_if.sv
// Valid/ready channel interfaces for the block: sample input, result output
// and window length configuration. Depends on rtmam_pkg for field types.
interface rtmam_in_if;
	logic valid;
	logic ready;
	logic [1:0] op;
	rtmam_pkg::temp_t temp_tenths;
	rtmam_pkg::humid_t humid_tenths;
	modport source(output valid, op, temp_tenths, humid_tenths, input ready);
	modport sink(input valid, op, temp_tenths, humid_tenths, output ready);
endinterface

interface rtmam_out_if;
	logic valid;
	logic ready;
	rtmam_pkg::temp_t avg_tenths;
	rtmam_pkg::temp_t min_tenths;
	rtmam_pkg::temp_t max_tenths;
	rtmam_pkg::pct_t humid_pct;
	modport source(output valid, avg_tenths, min_tenths, max_tenths, humid_pct,
		input ready);
	modport sink(input valid, avg_tenths, min_tenths, max_tenths, humid_pct,
		output ready);
endinterface

interface rtmam_cfg_if;
	logic valid;
	logic ready;
	logic [7:0] data;
	modport source(output valid, data, input ready);
	modport sink(input valid, data, output ready);
endinterface

// File: hdl/running_temp_min_avg_max.sv
// Running temperature minimum, average and maximum with last humidity.
// Depends on rtmam_pkg and the channel interfaces in rtmam_if.sv.
//
// Usage: items enter on the sample channel (op, temp_tenths, humid_tenths)
// and each produces exactly one item on the result channel (avg_tenths,
// min_tenths, max_tenths, humid_pct). The cfg channel writes the window
// length and is always ready. It must be written only while the block is
// idle; the block itself does not enforce this. A sample updates sum,
// count, minimum and maximum in the cycle it is accepted, then a
// bit-serial restoring divider produces the average one quotient bit per
// cycle, together with humidity / 10. A sample item passes through the
// divide and finish states before it loads the result register; the other
// commands go straight to the finish state. One item is in work at a time,
// and the next is accepted once the previous result is registered.
// The result register holds its item while the receiver stalls; an item
// that finishes in that time waits until the register is free.
// Reset sets the window length to 200 and clears all statistics, so the
// extremes read zero until the first sample or min/max reset command.
module running_temp_min_avg_max (
	input logic clk,
	input logic arst_n,
	rtmam_in_if.sink sample,
	rtmam_out_if.source result,
	rtmam_cfg_if.sink cfg
);
	import rtmam_pkg::*;

	state_t state_q, state_nx;
	count_t window_len_q;
	count_t count_q;
	sum_t sum_q;
	temp_t avg_q, min_q, max_q;
	logic extr_valid_q;
	pct_t hum_pct_q;
	logic res_valid_q;

	logic [MAG_W-1:0] div_num_q;
	logic [7:0] div_rem_q;
	count_t div_den_q;
	logic div_neg_q;
	logic [MAG_W-1:0] hum_num_q;
	logic [3:0] hum_rem_q;
	logic [4:0] step_q;

	temp_t avg_res_q, min_res_q, max_res_q;
	pct_t hum_res_q;

	logic accept, res_free, load_res;
	temp_t t_sat;
	humid_t h_sat;
	sum_t sum_nx;
	count_t count_nx;
	logic win_end;
	logic [8:0] div_trial;
	logic div_fit;
	logic [4:0] hum_trial;
	logic hum_fit;
	logic [MAG_W-1:0] div_num_nx, hum_num_nx;
	temp_t quot, avg_nx;

	assign accept = sample.valid && sample.ready;
	assign sample.ready = (state_q == ST_IDLE);
	assign cfg.ready = 1'b1;
	assign res_free = !res_valid_q || result.ready;
	assign load_res = (state_q == ST_FINISH) && res_free;

	always_comb begin
		priority if (sample.temp_tenths < TEMP_LO) begin
			t_sat = TEMP_LO;
		end else if (sample.temp_tenths > TEMP_HI) begin
			t_sat = TEMP_HI;
		end else begin
			t_sat = sample.temp_tenths;
		end
		h_sat = (sample.humid_tenths > HUMID_HI) ? HUMID_HI : sample.humid_tenths;
		sum_nx = sum_q + {{8{t_sat[10]}}, t_sat};
		count_nx = count_q + 8'd1;
		win_end = (count_nx == window_len_q) || (count_nx == COUNT_MAX);
	end

	always_comb begin
		div_trial = {div_rem_q, div_num_q[MAG_W-1]};
		div_fit = div_trial >= {1'b0, div_den_q};
		div_num_nx = {div_num_q[MAG_W-2:0], div_fit};
		hum_trial = {hum_rem_q, hum_num_q[MAG_W-1]};
		hum_fit = hum_trial >= HUM_DIVISOR;
		hum_num_nx = {hum_num_q[MAG_W-2:0], hum_fit};
		quot = div_num_nx[10:0];
		avg_nx = div_neg_q ? -quot : quot;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					state_nx = (sample.op == OP_SAMPLE) ? ST_DIVIDE : ST_FINISH;
				end
			end
			ST_DIVIDE: begin
				if (step_q == DIV_LAST) begin
					state_nx = ST_FINISH;
				end
			end
			ST_FINISH: begin
				if (res_free) begin
					state_nx = ST_IDLE;
				end
			end
			default: state_nx = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_len_q <= WINDOW_RESET;
			count_q <= '0;
			sum_q <= '0;
			avg_q <= '0;
			min_q <= '0;
			max_q <= '0;
			extr_valid_q <= 1'b0;
			hum_pct_q <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (cfg.valid && cfg.ready) begin
				window_len_q <= cfg.data;
			end
			if (accept) begin
				unique case (sample.op)
					OP_SAMPLE: begin
						count_q <= win_end ? '0 : count_nx;
						sum_q <= win_end ? '0 : sum_nx;
						if (!extr_valid_q || t_sat < min_q) begin
							min_q <= t_sat;
						end
						if (!extr_valid_q || t_sat > max_q) begin
							max_q <= t_sat;
						end
						extr_valid_q <= 1'b1;
					end
					OP_SET_EXTR: begin
						min_q <= avg_q;
						max_q <= avg_q;
						extr_valid_q <= 1'b1;
					end
					OP_CLEAR_WIN: begin
						count_q <= '0;
						sum_q <= '0;
					end
					default: begin
					end
				endcase
			end
			if (state_q == ST_DIVIDE && step_q == DIV_LAST) begin
				avg_q <= avg_nx;
				hum_pct_q <= hum_num_nx[6:0];
			end
			if (load_res) begin
				res_valid_q <= 1'b1;
			end else if (result.ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	// The divider works on the magnitude; the sign is applied at the last step.
	always_ff @(posedge clk) begin
		if (accept) begin
			div_num_q <= sum_nx[18] ? MAG_W'(-sum_nx) : sum_nx[MAG_W-1:0];
			div_neg_q <= sum_nx[18];
			div_den_q <= count_nx;
			div_rem_q <= '0;
			hum_num_q <= {{(MAG_W - 10){1'b0}}, h_sat};
			hum_rem_q <= '0;
			step_q <= '0;
		end else if (state_q == ST_DIVIDE) begin
			div_num_q <= div_num_nx;
			div_rem_q <= div_fit ? 8'(div_trial - {1'b0, div_den_q}) : div_trial[7:0];
			hum_num_q <= hum_num_nx;
			hum_rem_q <= hum_fit ? 4'(hum_trial - HUM_DIVISOR) : hum_trial[3:0];
			step_q <= step_q + 5'd1;
		end
		if (load_res) begin
			avg_res_q <= avg_q;
			min_res_q <= min_q;
			max_res_q <= max_q;
			hum_res_q <= hum_pct_q;
		end
	end

	assign result.valid = res_valid_q;
	assign result.avg_tenths = avg_res_q;
	assign result.min_tenths = min_res_q;
	assign result.max_tenths = max_res_q;
	assign result.humid_pct = hum_res_q;

	a_sample_divides: assert property (@(posedge clk) disable iff (!arst_n)
		accept && sample.op == OP_SAMPLE |=> state_q == ST_DIVIDE)
		else $error("sample item did not start the divider");

	a_step_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DIVIDE |-> step_q <= DIV_LAST)
		else $error("divider step count overran");

	a_rem_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DIVIDE |-> {1'b0, div_rem_q} < {1'b0, div_den_q}
			&& hum_rem_q < 4'(HUM_DIVISOR))
		else $error("divider remainder not below divisor");

	a_extr_order: assert property (@(posedge clk) disable iff (!arst_n)
		extr_valid_q |-> min_q <= max_q)
		else $error("minimum above maximum");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q != COUNT_MAX)
		else $error("sample count reached its limit without a window restart");

endmodule

// File: dv/running_temp_min_avg_max_tb.sv
// Testbench for running_temp_min_avg_max: directed and random items on the sample
// channel, window length writes, and per-field checks of every result item.
// Depends on rtmam_pkg, the channel interfaces in rtmam_if.sv and the block itself.
module running_temp_min_avg_max_tb;
	import rtmam_pkg::*;

	localparam logic [1:0] OP_UNUSED = 2'd3;
	localparam int HOLD_CYCLES = 400;
	localparam int CYCLE_LIMIT = 500000;

	typedef struct packed {
		temp_t avg;
		temp_t mn;
		temp_t mx;
		pct_t pct;
	} stats_t;

	logic clk = 1'b0;
	logic arst_n;

	rtmam_in_if in_ch();
	rtmam_out_if out_ch();
	rtmam_cfg_if cfg_ch();

	running_temp_min_avg_max dut (
		.clk(clk),
		.arst_n(arst_n),
		.sample(in_ch),
		.result(out_ch),
		.cfg(cfg_ch)
	);

	// Expected statistics, one entry per accepted item.
	stats_t expected_stats[$];

	int win_len;
	int n_samples;
	int temp_acc;
	int avg_now;
	int min_now;
	int max_now;
	bit extr_set;
	int humid_last;

	int mismatches = 0;
	int items_sent = 0;
	int results_seen = 0;
	int windows_written = 0;
	int cycles = 0;
	int hold_req = 0;
	bit jitter = 1'b1;

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("%0t: timeout with %0d results outstanding", $time, expected_stats.size());
			$display("FAILURE");
			$finish;
		end
	end

	function automatic stats_t update_stats(input logic [1:0] op, input temp_t t_in,
		input humid_t h_in);
		int t;
		int h;
		stats_t r;
		case (op)
			OP_SAMPLE: begin
				t = t_in;
				h = h_in;
				if (t < TEMP_LO)
					t = TEMP_LO;
				if (t > TEMP_HI)
					t = TEMP_HI;
				if (h > HUMID_HI)
					h = HUMID_HI;
				humid_last = h;
				n_samples++;
				temp_acc += t;
				avg_now = temp_acc / n_samples;
				if (!extr_set) begin
					min_now = t;
					max_now = t;
					extr_set = 1'b1;
				end else begin
					if (t < min_now)
						min_now = t;
					if (t > max_now)
						max_now = t;
				end
				if (n_samples == win_len || n_samples >= 255) begin
					n_samples = 0;
					temp_acc = 0;
				end
			end
			OP_SET_EXTR: begin
				min_now = avg_now;
				max_now = avg_now;
				extr_set = 1'b1;
			end
			OP_CLEAR_WIN: begin
				n_samples = 0;
				temp_acc = 0;
			end
			default: begin
			end
		endcase
		r.avg = avg_now[10:0];
		r.mn = min_now[10:0];
		r.mx = max_now[10:0];
		r.pct = pct_t'(humid_last / 10);
		return r;
	endfunction

	function automatic void check_field(input string name, input logic signed [11:0] want,
		input logic signed [11:0] got);
		if (got !== want) begin
			mismatches++;
			$display("%0t: %s expected %0d, got %0d", $time, name, want, got);
		end
	endfunction

	always @(posedge clk) begin : check_results
		stats_t want;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			if (expected_stats.size() == 0) begin
				mismatches++;
				$display("%0t: result item with none expected, expected nothing, got avg %0d",
					$time, out_ch.avg_tenths);
			end else begin
				want = expected_stats.pop_front();
				results_seen++;
				check_field("avg_tenths", want.avg, out_ch.avg_tenths);
				check_field("min_tenths", want.mn, out_ch.min_tenths);
				check_field("max_tenths", want.mx, out_ch.max_tenths);
				check_field("humid_pct", want.pct, out_ch.humid_pct);
			end
		end
	end

	// The receiver stalls at random, or for a long stretch on request.
	initial begin
		int hold_left;
		int seen_req;
		hold_left = 0;
		seen_req = 0;
		out_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req != seen_req) begin
				seen_req = hold_req;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_ch.ready <= 1'b0;
			end else begin
				out_ch.ready <= !(jitter && $urandom_range(0, 99) < 10);
			end
		end
	end

	task automatic send_item(input logic [1:0] op, input temp_t t, input humid_t h);
		@(negedge clk);
		if (jitter) begin
			while ($urandom_range(0, 99) < 10) begin
				in_ch.valid <= 1'b0;
				@(negedge clk);
			end
		end
		in_ch.valid <= 1'b1;
		in_ch.op <= op;
		in_ch.temp_tenths <= t;
		in_ch.humid_tenths <= h;
		do
			@(posedge clk);
		while (!in_ch.ready);
		expected_stats.push_back(update_stats(op, t, h));
		items_sent++;
	endtask

	function automatic temp_t rand_temp();
		if ($urandom_range(0, 9) == 0)
			return temp_t'($urandom);
		return temp_t'($urandom_range(0, 1200) - 400);
	endfunction

	function automatic humid_t rand_humid();
		if ($urandom_range(0, 9) == 0)
			return humid_t'($urandom);
		return humid_t'($urandom_range(0, 1000));
	endfunction

	task automatic send_random_sample();
		send_item(OP_SAMPLE, rand_temp(), rand_humid());
	endtask

	task automatic send_random_item();
		int pick;
		logic [1:0] op;
		pick = $urandom_range(0, 99);
		if (pick < 82)
			op = OP_SAMPLE;
		else if (pick < 89)
			op = OP_SET_EXTR;
		else if (pick < 95)
			op = OP_CLEAR_WIN;
		else
			op = OP_UNUSED;
		send_item(op, rand_temp(), rand_humid());
	endtask

	task automatic drain();
		@(negedge clk);
		in_ch.valid <= 1'b0;
		while (expected_stats.size() != 0)
			@(negedge clk);
	endtask

	task automatic write_window(input int len);
		drain();
		@(negedge clk);
		cfg_ch.valid <= 1'b1;
		cfg_ch.data <= len[7:0];
		do
			@(posedge clk);
		while (!cfg_ch.ready);
		win_len = len & 8'hFF;
		windows_written++;
		@(negedge clk);
		cfg_ch.valid <= 1'b0;
	endtask

	task automatic test_directed();
		send_item(OP_UNUSED, temp_t'(123), humid_t'(456));
		send_item(OP_CLEAR_WIN, temp_t'(-5), humid_t'(7));
		send_item(OP_SAMPLE, temp_t'(1023), humid_t'(1023));
		send_item(OP_SAMPLE, temp_t'(-1024), humid_t'(0));
		send_item(OP_SAMPLE, TEMP_LO, HUMID_HI);
		send_item(OP_SAMPLE, TEMP_HI, humid_t'(999));
		send_item(OP_SAMPLE, temp_t'(0), humid_t'(5));
		send_item(OP_SAMPLE, temp_t'(-1), humid_t'(10));
		send_item(OP_SET_EXTR, temp_t'(0), humid_t'(0));
		send_item(OP_SAMPLE, temp_t'(801), humid_t'(1001));
		send_item(OP_SAMPLE, temp_t'(-401), humid_t'(512));
		send_item(OP_UNUSED, temp_t'(-1), humid_t'(1023));
		send_item(OP_CLEAR_WIN, temp_t'(0), humid_t'(0));
		send_item(OP_SAMPLE, temp_t'(-399), humid_t'(9));
		send_item(OP_SET_EXTR, temp_t'(0), humid_t'(0));
		send_item(OP_SAMPLE, temp_t'(799), humid_t'(341));
		send_item(OP_SAMPLE, temp_t'(-400), humid_t'(682));
	endtask

	task automatic test_window_lengths();
		write_window(1);
		repeat (6)
			send_random_sample();
		write_window(255);
		repeat (260)
			send_random_sample();
		// With a zero length the window only restarts at the count ceiling.
		write_window(0);
		repeat (260)
			send_random_sample();
		// A length below the current count is passed and the count runs to its ceiling.
		write_window(WINDOW_RESET);
		send_item(OP_CLEAR_WIN, temp_t'(0), humid_t'(0));
		repeat (30)
			send_random_sample();
		write_window(10);
		repeat (230)
			send_random_sample();
	endtask

	task automatic test_backpressure();
		drain();
		jitter = 1'b0;
		@(posedge clk);
		hold_req++;
		repeat (30)
			send_random_item();
		drain();
		jitter = 1'b1;
	endtask

	task automatic test_random();
		int lens[6];
		lens = '{WINDOW_RESET, 2, 7, $urandom_range(1, 255), 13, 100};
		for (int i = 0; i < 6; i++) begin
			write_window(lens[i]);
			jitter = (i != 4);
			repeat (180)
				send_random_item();
		end
		jitter = 1'b1;
	endtask

	initial begin
		arst_n = 1'b0;
		in_ch.valid = 1'b0;
		in_ch.op = OP_SAMPLE;
		in_ch.temp_tenths = '0;
		in_ch.humid_tenths = '0;
		cfg_ch.valid = 1'b0;
		cfg_ch.data = '0;
		win_len = WINDOW_RESET;
		n_samples = 0;
		temp_acc = 0;
		avg_now = 0;
		min_now = 0;
		max_now = 0;
		extr_set = 1'b0;
		humid_last = 0;
		repeat (10)
			@(negedge clk);
		arst_n = 1'b1;

		test_directed();
		test_window_lengths();
		test_backpressure();
		test_random();

		drain();
		repeat (40)
			@(negedge clk);
		$display("Checked %0d results from %0d items over %0d window length writes,",
			results_seen, items_sent, windows_written);
		$display("covering all op codes, saturated inputs and a long receiver stall.");
		if (mismatches == 0) begin
			$display("SUCCESS");
		end else begin
			$display("%0d mismatches", mismatches);
			$display("FAILURE");
		end
		$finish;
	end

endmodule
